// ----- rtl/core/srf_pkg.sv -----
// ----------------------------------------------------------------------------
// srf_pkg
// Shared types and constants of the sensor reading ASCII framer: reading kinds,
// clamp limits, decimal weights and the fixed frame template.
// ----------------------------------------------------------------------------
package srf_pkg;

  typedef enum logic [1:0] {
    KIND_TEMP = 2'd0,
    KIND_PRES = 2'd1,
    KIND_HUM  = 2'd2,
    KIND_NONE = 2'd3
  } srf_kind_t;

  // One reading on its way through the pipeline
  typedef struct packed {
    srf_kind_t        kind;
    logic             neg;
    logic [20:0]      mag;
    logic [5:0][3:0]  dig;
  } srf_item_t;

  localparam int unsigned FRAME_LEN = 20;
  localparam int unsigned CNT_W     = $clog2(FRAME_LEN);
  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(FRAME_LEN - 1);

  localparam logic [20:0] TEMP_MAX  = 21'd99999;
  localparam logic [20:0] PRES_MAX  = 21'd999999;
  localparam logic [19:0] HUM_MAX   = 20'd999999;
  localparam logic [9:0]  HUM_SCALE = 10'd1000;

  localparam int unsigned NDIG_STG = 5;
  localparam logic [19:0] DIG_POW [NDIG_STG] = '{
    20'd100000, 20'd10000, 20'd1000, 20'd100, 20'd10
  };

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  localparam logic [7:0] FRAME_TMPL [FRAME_LEN] = '{
    8'h73, 8'h5F, 8'h73, 8'h73, 8'h5F, 8'h31, 8'h5F, 8'h00, 8'h00, 8'h5F,
    8'h30, 8'h30, 8'h30, 8'h30, 8'h5F, 8'h30, 8'h30, 8'h30, 8'h5F, 8'h65
  };

  function automatic logic [7:0] asc_digit(input logic [3:0] d);
    asc_digit = CH_ZERO | {4'h0, d};
  endfunction

endpackage

// ----- rtl/core/srf_scale.sv -----
// ----------------------------------------------------------------------------
// srf_scale
// Three-stage front end: sign and magnitude, per-kind clamp or humidity
// scaling by 1000/1024, final humidity clamp.
// ----------------------------------------------------------------------------
module srf_scale (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_kind,
  input  logic signed [20:0]  in_reading,
  output logic                out_valid,
  input  logic                out_ready,
  output srf_pkg::srf_item_t  out_item
);
  import srf_pkg::*;

  logic      v0_r, v1_r, v2_r;
  srf_item_t s0_r, s1_r, s2_r;
  srf_item_t s0_nxt, s1_nxt, s2_nxt;
  logic      rdy0, rdy1, rdy2;
  logic [20:0] raw;
  logic [29:0] prod;

  assign rdy2     = !v2_r || out_ready;
  assign rdy1     = !v1_r || rdy2;
  assign rdy0     = !v0_r || rdy1;
  assign in_ready = rdy0;

  assign raw = in_reading;

  // sign and magnitude
  always_comb begin
    s0_nxt      = '0;
    s0_nxt.kind = srf_kind_t'(in_kind);
    s0_nxt.neg  = raw[20];
    case (srf_kind_t'(in_kind))
      KIND_TEMP: s0_nxt.mag = raw[20] ? (~raw + 21'd1) : raw;
      KIND_PRES,
      KIND_HUM:  s0_nxt.mag = raw[20] ? 21'd0 : raw;
      default:   s0_nxt.mag = 21'd0;
    endcase
  end

  assign prod = s0_r.mag[19:0] * HUM_SCALE;

  // clamp or scale
  always_comb begin
    s1_nxt = s0_r;
    case (s0_r.kind)
      KIND_TEMP: s1_nxt.mag = (s0_r.mag > TEMP_MAX) ? TEMP_MAX : s0_r.mag;
      KIND_PRES: s1_nxt.mag = (s0_r.mag > PRES_MAX) ? PRES_MAX : s0_r.mag;
      KIND_HUM:  s1_nxt.mag = {1'b0, prod[29:10]};
      default:   s1_nxt.mag = 21'd0;
    endcase
  end

  always_comb begin
    s2_nxt = s1_r;
    if (s1_r.mag[19:0] > HUM_MAX) begin
      s2_nxt.mag = {1'b0, HUM_MAX};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy0) begin
        v0_r <= in_valid;
      end
      if (rdy1) begin
        v1_r <= v0_r;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0) begin
      s0_r <= s0_nxt;
    end
    if (rdy1) begin
      s1_r <= s1_nxt;
    end
    if (rdy2) begin
      s2_r <= s2_nxt;
    end
  end

  assign out_valid = v2_r;
  assign out_item  = s2_r;

endmodule

// ----- rtl/core/srf_bcd.sv -----
// ----------------------------------------------------------------------------
// srf_bcd
// Binary to decimal conversion, one digit per pipeline stage, most
// significant first; the last remainder is the units digit.
// ----------------------------------------------------------------------------
module srf_bcd (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  srf_pkg::srf_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output srf_pkg::srf_item_t  out_item
);
  import srf_pkg::*;

  logic      v_r [NDIG_STG];
  srf_item_t st_r [NDIG_STG];
  logic [NDIG_STG:0] rdy;

  // extract the digit of weight DIG_POW[k] and drop it from the remainder
  function automatic srf_item_t dig_step(input srf_item_t it, input int unsigned k);
    srf_item_t   o;
    logic [3:0]  d;
    logic [19:0] w;
    o = it;
    d = 4'd0;
    w = 20'd0;
    for (int unsigned j = 1; j <= 9; j++) begin
      if (it.mag[19:0] >= 20'(j) * DIG_POW[k]) begin
        d = 4'(j);
        w = 20'(j) * DIG_POW[k];
      end
    end
    o.dig[3'(5 - k)] = d;
    o.mag = it.mag - {1'b0, w};
    return o;
  endfunction

  assign rdy[NDIG_STG] = out_ready;
  assign in_ready      = rdy[0];

  for (genvar k = 0; k < NDIG_STG; k++) begin : g_stg
    srf_item_t src;
    logic      src_v;

    if (k == 0) begin : g_first
      assign src   = in_item;
      assign src_v = in_valid;
    end else begin : g_next
      assign src   = st_r[k-1];
      assign src_v = v_r[k-1];
    end

    assign rdy[k] = !v_r[k] || rdy[k+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_r[k] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        st_r[k] <= dig_step(src, k);
      end
    end
  end

  always_comb begin
    out_item        = st_r[NDIG_STG-1];
    out_item.dig[0] = st_r[NDIG_STG-1].mag[3:0];
  end

  assign out_valid = v_r[NDIG_STG-1];

endmodule

// ----- rtl/core/srf_serial.sv -----
// ----------------------------------------------------------------------------
// srf_serial
// Frame serializer: holds one converted reading and emits its 20 ASCII bytes,
// one beat per cycle, through an output register; loads the next reading on
// the last byte so frames follow without a gap.
// ----------------------------------------------------------------------------
module srf_serial (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  srf_pkg::srf_item_t  in_item,
  output logic                out_valid,
  output logic [7:0]          out_char_byte,
  output logic                out_frame_end
);
  import srf_pkg::*;

  logic             act_r, act_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  srf_item_t        item_r;
  logic             load;
  logic             last;
  logic [7:0]       frame [FRAME_LEN];
  logic             oval_r;
  logic [7:0]       ochar_r;
  logic             oend_r;

  assign last     = act_r && (cnt_r == LAST_IDX);
  assign in_ready = !act_r || last;
  assign load     = in_valid && in_ready;

  always_comb begin
    act_nxt = act_r;
    cnt_nxt = cnt_r;
    if (load) begin
      act_nxt = 1'b1;
      cnt_nxt = '0;
    end else if (last) begin
      act_nxt = 1'b0;
    end else if (act_r) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end
  end

  // assemble the frame of the held reading
  always_comb begin
    frame = FRAME_TMPL;
    case (item_r.kind)
      KIND_TEMP: begin
        frame[5]  = 8'h32;
        frame[7]  = 8'h74;
        frame[8]  = 8'h70;
        frame[10] = item_r.neg ? CH_MINUS : CH_PLUS;
        frame[11] = asc_digit(item_r.dig[4]);
        frame[12] = asc_digit(item_r.dig[3]);
        frame[13] = asc_digit(item_r.dig[2]);
        frame[15] = asc_digit(item_r.dig[1]);
        frame[16] = asc_digit(item_r.dig[0]);
      end
      KIND_PRES: begin
        frame[5]  = 8'h34;
        frame[7]  = 8'h70;
        frame[8]  = 8'h72;
        frame[10] = asc_digit(item_r.dig[5]);
        frame[11] = asc_digit(item_r.dig[4]);
        frame[12] = asc_digit(item_r.dig[3]);
        frame[13] = asc_digit(item_r.dig[2]);
        frame[15] = asc_digit(item_r.dig[1]);
        frame[16] = asc_digit(item_r.dig[0]);
      end
      KIND_HUM: begin
        frame[5]  = 8'h33;
        frame[7]  = 8'h68;
        frame[8]  = 8'h75;
        frame[11] = asc_digit(item_r.dig[5]);
        frame[12] = asc_digit(item_r.dig[4]);
        frame[13] = asc_digit(item_r.dig[3]);
        frame[15] = asc_digit(item_r.dig[2]);
        frame[16] = asc_digit(item_r.dig[1]);
        frame[17] = asc_digit(item_r.dig[0]);
      end
      default: begin
        frame = FRAME_TMPL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= 1'b0;
      cnt_r  <= '0;
      oval_r <= 1'b0;
      oend_r <= 1'b0;
    end else begin
      act_r  <= act_nxt;
      cnt_r  <= cnt_nxt;
      oval_r <= act_r;
      oend_r <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
    ochar_r <= frame[cnt_r];
  end

  assign out_valid     = oval_r;
  assign out_char_byte = ochar_r;
  assign out_frame_end = oend_r;

endmodule

// ----- rtl/core/sensor_reading_ascii_framer_unit.sv -----
// ----------------------------------------------------------------------------
// sensor_reading_ascii_framer_unit
// Turns one sensor reading into a 20-byte ASCII frame, one byte a cycle.
// ----------------------------------------------------------------------------
// A reading is taken at a clock edge with start high and busy low. Its first
// byte passes scaling, digit, holding and output registers to out_valid;
// the 20 bytes follow back to back with out_frame_end on the last, and the
// receiver cannot stall them. An active serializer takes a new reading only
// with its last byte. The three scaling and five digit stages buffer further
// readings, so start may be pulsed back to back; busy rises once they fill.
module sensor_reading_ascii_framer_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_kind,
  input  logic signed [20:0] in_reading,
  output logic               out_valid,
  output logic [7:0]         out_char_byte,
  output logic               out_frame_end
);
  import srf_pkg::*;

  logic      sc_ready;
  logic      sc_valid, bc_ready;
  srf_item_t sc_item;
  logic      bc_valid, se_ready;
  srf_item_t bc_item;

  assign busy = !sc_ready;

  srf_scale u_scale (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (start),
    .in_ready   (sc_ready),
    .in_kind    (in_kind),
    .in_reading (in_reading),
    .out_valid  (sc_valid),
    .out_ready  (bc_ready),
    .out_item   (sc_item)
  );

  srf_bcd u_bcd (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sc_valid),
    .in_ready  (bc_ready),
    .in_item   (sc_item),
    .out_valid (bc_valid),
    .out_ready (se_ready),
    .out_item  (bc_item)
  );

  srf_serial u_serial (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (bc_valid),
    .in_ready      (se_ready),
    .in_item       (bc_item),
    .out_valid     (out_valid),
    .out_char_byte (out_char_byte),
    .out_frame_end (out_frame_end)
  );

endmodule

// ----- rtl/core/srf_chk.sv -----
// ----------------------------------------------------------------------------
// srf_chk
// Port-level checks of the framer: frame boundaries and contiguous beats.
// ----------------------------------------------------------------------------
module srf_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic [7:0]         out_char_byte,
  input logic               out_frame_end
);

  a_end_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_frame_end |-> out_valid)
    else $error("frame end without valid beat");

  a_end_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |-> out_char_byte == 8'h65)
    else $error("last beat is not the end marker");

  a_first_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (!$past(out_valid) || $past(out_frame_end)) |-> out_char_byte == 8'h73)
    else $error("first beat is not the start marker");

  a_contig: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_frame_end |=> out_valid)
    else $error("gap inside a frame");

endmodule

bind sensor_reading_ascii_framer_unit srf_chk u_srf_chk (.*);
